/* sv/dcpa_pkg.sv */
// ----------------------------------------------------------------------------
// dcpa_pkg
// Shared types and constants for the daisy-chain pulse address block:
// field widths, register indexes, register reset values and the result beat layout.
// ----------------------------------------------------------------------------
package dcpa_pkg;

   // field and counter widths
   localparam int unsigned TickWidth   = 16;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned PulseWidth  = 9;
   localparam int unsigned AddrWidth   = 7;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDatWidth = 16;

   // register indexes on the csr port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TIMEOUT_TICKS        = 2'd0,
      CSR_TIMEOUTS_PER_RELEASE = 2'd1,
      CSR_PULSE_HALF_TICKS     = 2'd2
   } csr_idx_type;

   // register reset values
   localparam logic [TickWidth-1:0]  TimeoutTicksRst       = 16'd256;
   localparam logic [CountWidth-1:0] TimeoutsPerReleaseRst = 8'd30;
   localparam logic [TickWidth-1:0]  PulseHalfTicksRst     = 16'd8;

   // one result beat
   typedef struct packed {
      logic                 addr_out_level;
      logic                 irq_level;
      logic                 address_valid;
      logic [AddrWidth-1:0] address_value;
   } rsp_beat_type;

endpackage

/* sv/daisy_chain_pulse_address.sv */
// ----------------------------------------------------------------------------
// daisy_chain_pulse_address
// Daisy-chain address receiver and forwarder. Counts falling edges on the
// incoming address line, decodes an address after a quiet timeout, forwards
// a pulse train on the outgoing line and drives the interrupt line.
// ----------------------------------------------------------------------------
//
//  port group | direction | handshake             | payload
//  -----------+-----------+-----------------------+-----------------------------
//  req_*      | in        | req_valid / req_ready | addr_in_level, raise_irq
//  rsp_*      | out       | rsp_valid / rsp_ready | addr_out_level, irq_level,
//             |           |                       | address_valid, address_value
//  csr_*      | in        | csr_wr_en             | csr_index, csr_wdata
//
//  One beat per cycle while req_ready is high: the whole tick update is done in
//  the accepting cycle and its result is written to a two-entry output buffer,
//  from which the registered result is presented on the rsp port.
//  req_ready drops only while both buffer entries hold unread results.
//  Synchronous active-high reset sets all state but buffer data to defaults.
//  csr writes take effect at the next edge and are meant for an idle block.
// ----------------------------------------------------------------------------
module daisy_chain_pulse_address (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_addr_in_level,
   input  logic                            req_raise_irq,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_addr_out_level,
   output logic                            rsp_irq_level,
   output logic                            rsp_address_valid,
   output logic [dcpa_pkg::AddrWidth-1:0]  rsp_address_value,
   input  logic                            csr_wr_en,
   input  logic [dcpa_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [dcpa_pkg::CsrDatWidth-1:0] csr_wdata
);

   // configuration registers
   logic [dcpa_pkg::TickWidth-1:0]  timeout_ticks_ff;
   logic [dcpa_pkg::CountWidth-1:0] timeouts_per_release_ff;
   logic [dcpa_pkg::TickWidth-1:0]  pulse_half_ticks_ff;

   // tick state
   logic                            prev_level_ff, prev_level_in;
   logic [dcpa_pkg::CountWidth-1:0] pulse_count_ff, pulse_count_in;
   logic                            timer_running_ff, timer_running_in;
   logic [dcpa_pkg::TickWidth-1:0]  tick_count_ff, tick_count_in;
   logic [dcpa_pkg::CountWidth-1:0] timeout_count_ff, timeout_count_in;
   logic                            irq_state_ff, irq_state_in;
   logic [dcpa_pkg::PulseWidth-1:0] pulses_left_ff, pulses_left_in;
   logic [dcpa_pkg::TickWidth-1:0]  phase_ticks_ff, phase_ticks_in;
   logic                            out_state_ff, out_state_in;

   // output buffer
   dcpa_pkg::rsp_beat_type          buf_ff [2];
   logic                            head_ff;
   logic [1:0]                      count_ff;
   dcpa_pkg::rsp_beat_type          beat_in;

   logic push;
   logic pop;
   logic tail;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff        <= dcpa_pkg::TimeoutTicksRst;
         timeouts_per_release_ff <= dcpa_pkg::TimeoutsPerReleaseRst;
         pulse_half_ticks_ff     <= dcpa_pkg::PulseHalfTicksRst;
      end else if (csr_wr_en) begin
         case (dcpa_pkg::csr_idx_type'(csr_index))
            dcpa_pkg::CSR_TIMEOUT_TICKS: begin
               timeout_ticks_ff <= csr_wdata;
            end
            dcpa_pkg::CSR_TIMEOUTS_PER_RELEASE: begin
               timeouts_per_release_ff <= csr_wdata[dcpa_pkg::CountWidth-1:0];
            end
            dcpa_pkg::CSR_PULSE_HALF_TICKS: begin
               pulse_half_ticks_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // one tick of the receiver, sender and timer
   always_comb begin
      logic                            sending;
      logic                            start;
      logic [dcpa_pkg::TickWidth-1:0]  phase_inc;
      logic [dcpa_pkg::TickWidth-1:0]  tick_inc;
      logic [dcpa_pkg::CountWidth-1:0] tout_inc;

      prev_level_in    = prev_level_ff;
      pulse_count_in   = pulse_count_ff;
      timer_running_in = timer_running_ff;
      tick_count_in    = tick_count_ff;
      timeout_count_in = timeout_count_ff;
      irq_state_in     = irq_state_ff;
      pulses_left_in   = pulses_left_ff;
      phase_ticks_in   = phase_ticks_ff;
      out_state_in     = out_state_ff;
      beat_in          = '0;

      sending   = (pulses_left_ff != '0);
      start     = 1'b0;
      phase_inc = phase_ticks_ff + 16'd1;

      // advance the outgoing pulse train
      if (sending) begin
         phase_ticks_in = phase_inc;
         if (phase_inc >= pulse_half_ticks_ff) begin
            phase_ticks_in = '0;
            if (out_state_ff) begin
               out_state_in = 1'b0;
            end else begin
               pulses_left_in = pulses_left_ff - 9'd1;
               out_state_in   = (pulses_left_in != '0);
            end
         end
      end

      // falling edge on the incoming line
      if (!sending && prev_level_ff && !req_addr_in_level) begin
         start          = 1'b1;
         pulse_count_in = pulse_count_ff + 8'd1;
      end
      prev_level_in = req_addr_in_level;

      // interrupt raise request
      if (req_raise_irq) begin
         irq_state_in = 1'b1;
         start        = 1'b1;
      end
      if (start) begin
         timer_running_in = 1'b1;
         tick_count_in    = '0;
      end

      // timeout timer
      tick_inc = tick_count_in + 16'd1;
      tout_inc = timeout_count_ff + 8'd1;
      if (timer_running_in && !sending) begin
         tick_count_in = tick_inc;
         if (tick_inc >= timeout_ticks_ff) begin
            tick_count_in = '0;
            if (pulse_count_in != '0) begin
               // even count: decode and forward, odd count: drop
               if (!pulse_count_in[0]) begin
                  beat_in.address_valid = 1'b1;
                  beat_in.address_value = pulse_count_in[dcpa_pkg::AddrWidth:1];
                  pulses_left_in = {1'b0, pulse_count_in} + 9'd2;
                  phase_ticks_in = '0;
                  out_state_in   = 1'b1;
               end
               pulse_count_in = '0;
            end
            timeout_count_in = tout_inc;
            if (tout_inc >= timeouts_per_release_ff) begin
               timer_running_in = 1'b0;
               tick_count_in    = '0;
               timeout_count_in = '0;
               irq_state_in     = 1'b0;
            end
         end
      end

      beat_in.addr_out_level = out_state_in;
      beat_in.irq_level      = irq_state_in;
   end

   // handshake
   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign tail      = head_ff ^ count_ff[0];

   // state update on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff    <= 1'b1;
         pulse_count_ff   <= '0;
         timer_running_ff <= 1'b0;
         tick_count_ff    <= '0;
         timeout_count_ff <= '0;
         irq_state_ff     <= 1'b0;
         pulses_left_ff   <= '0;
         phase_ticks_ff   <= '0;
         out_state_ff     <= 1'b0;
      end else if (push) begin
         prev_level_ff    <= prev_level_in;
         pulse_count_ff   <= pulse_count_in;
         timer_running_ff <= timer_running_in;
         tick_count_ff    <= tick_count_in;
         timeout_count_ff <= timeout_count_in;
         irq_state_ff     <= irq_state_in;
         pulses_left_ff   <= pulses_left_in;
         phase_ticks_ff   <= phase_ticks_in;
         out_state_ff     <= out_state_in;
      end
   end

   // output buffer payload
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[tail] <= beat_in;
      end
   end

   // output buffer pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (pop) begin
            head_ff <= ~head_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // result ports
   assign rsp_addr_out_level = buf_ff[head_ff].addr_out_level;
   assign rsp_irq_level      = buf_ff[head_ff].irq_level;
   assign rsp_address_valid  = buf_ff[head_ff].address_valid;
   assign rsp_address_value  = buf_ff[head_ff].address_value;

endmodule

/* test/daisy_chain_pulse_address_tb.sv */
// ----------------------------------------------------------------------------
// daisy_chain_pulse_address_tb
// Self-checking bench for the daisy-chain pulse address block. Base ticks
// are fed as request beats; a scoreboard class predicts each result beat
// from its own copy of the block state and checks every accepted result in
// order. Runs a short directed sequence, then well-formed pulse trains with
// random content plus line noise over several register settings and
// sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module daisy_chain_pulse_address_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // predicts one result beat per accepted tick and checks results in order
   class address_tick_scoreboard;
      // register copies
      bit [dcpa_pkg::TickWidth-1:0]  tmo_limit;
      bit [dcpa_pkg::CountWidth-1:0] release_limit;
      bit [dcpa_pkg::TickWidth-1:0]  half_period;
      // block state copies
      bit                            line_prev;
      bit [dcpa_pkg::CountWidth-1:0] edge_count;
      bit                            timer_on;
      bit [dcpa_pkg::TickWidth-1:0]  tick_cnt;
      bit [dcpa_pkg::CountWidth-1:0] tmo_cnt;
      bit                            irq_on;
      bit [dcpa_pkg::PulseWidth-1:0] pulses_rem;
      bit [dcpa_pkg::TickWidth-1:0]  phase_cnt;
      bit                            out_high;

      dcpa_pkg::rsp_beat_type expected_beats[$];
      int errors;

      function new();
         tmo_limit     = dcpa_pkg::TimeoutTicksRst;
         release_limit = dcpa_pkg::TimeoutsPerReleaseRst;
         half_period   = dcpa_pkg::PulseHalfTicksRst;
         line_prev     = 1'b1;
         edge_count    = '0;
         timer_on      = 1'b0;
         tick_cnt      = '0;
         tmo_cnt       = '0;
         irq_on        = 1'b0;
         pulses_rem    = '0;
         phase_cnt     = '0;
         out_high      = 1'b0;
         errors        = 0;
      endfunction

      function void set_reg(dcpa_pkg::csr_idx_type idx,
                            bit [dcpa_pkg::CsrDatWidth-1:0] value);
         case (idx)
            dcpa_pkg::CSR_TIMEOUT_TICKS:        tmo_limit = value;
            dcpa_pkg::CSR_TIMEOUTS_PER_RELEASE:
               release_limit = value[dcpa_pkg::CountWidth-1:0];
            dcpa_pkg::CSR_PULSE_HALF_TICKS:     half_period = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // one base tick of the block
      function void note_tick(bit level, bit raise);
         bit                     sending;
         bit                     start;
         dcpa_pkg::rsp_beat_type beat;
         sending = (pulses_rem != '0);
         start   = 1'b0;
         beat    = '0;

         // advance the outgoing train
         if (sending) begin
            phase_cnt = phase_cnt + 16'd1;
            if (phase_cnt >= half_period) begin
               phase_cnt = '0;
               if (out_high) begin
                  out_high = 1'b0;
               end else begin
                  pulses_rem = pulses_rem - 9'd1;
                  out_high   = (pulses_rem != '0);
               end
            end
         end

         // falling edge counts only while not sending
         if (!sending && line_prev && !level) begin
            start      = 1'b1;
            edge_count = edge_count + 8'd1;
         end
         line_prev = level;

         if (raise) begin
            irq_on = 1'b1;
            start  = 1'b1;
         end
         if (start) begin
            timer_on = 1'b1;
            tick_cnt = '0;
         end

         // timer holds while sending
         if (timer_on && !sending) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= tmo_limit) begin
               tick_cnt = '0;
               if (edge_count != '0) begin
                  if (!edge_count[0]) begin
                     beat.address_valid = 1'b1;
                     beat.address_value = edge_count[dcpa_pkg::AddrWidth:1];
                     pulses_rem = {1'b0, edge_count} + 9'd2;
                     phase_cnt  = '0;
                     out_high   = 1'b1;
                  end
                  edge_count = '0;
               end
               tmo_cnt = tmo_cnt + 8'd1;
               if (tmo_cnt >= release_limit) begin
                  timer_on = 1'b0;
                  tick_cnt = '0;
                  tmo_cnt  = '0;
                  irq_on   = 1'b0;
               end
            end
         end

         beat.addr_out_level = out_high;
         beat.irq_level      = irq_on;
         expected_beats.push_back(beat);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_beat(bit out_lvl, bit irq_lvl, bit addr_vld,
                      bit [dcpa_pkg::AddrWidth-1:0] addr);
         dcpa_pkg::rsp_beat_type want;
         if (expected_beats.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = expected_beats.pop_front();
            if (out_lvl !== want.addr_out_level)
               report($sformatf("addr_out_level got %0b want %0b", out_lvl,
                                want.addr_out_level));
            if (irq_lvl !== want.irq_level)
               report($sformatf("irq_level got %0b want %0b", irq_lvl, want.irq_level));
            if (addr_vld !== want.address_valid)
               report($sformatf("address_valid got %0b want %0b", addr_vld,
                                want.address_valid));
            if (addr !== want.address_value)
               report($sformatf("address_value got %0d want %0d", addr,
                                want.address_value));
         end
      endtask
   endclass

   // clock and block ports
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_addr_in_level = 1'b1;
   logic                             req_raise_irq = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_addr_out_level;
   logic                             rsp_irq_level;
   logic                             rsp_address_valid;
   logic [dcpa_pkg::AddrWidth-1:0]   rsp_address_value;
   logic                             csr_wr_en = 1'b0;
   logic [dcpa_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [dcpa_pkg::CsrDatWidth-1:0] csr_wdata = '0;

   address_tick_scoreboard sb;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int ticks_sent      = 0;

   daisy_chain_pulse_address dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_addr_in_level  (req_addr_in_level),
      .req_raise_irq      (req_raise_irq),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_addr_out_level (rsp_addr_out_level),
      .rsp_irq_level      (rsp_irq_level),
      .rsp_address_valid  (rsp_address_valid),
      .rsp_address_value  (rsp_address_value),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_tick(req_addr_in_level, req_raise_irq);
   end

   // accepted result beats are checked
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat(rsp_addr_out_level, rsp_irq_level, rsp_address_valid,
                       rsp_address_value);
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic bit rand_raise();
      return ($urandom_range(0, 15) == 0);
   endfunction

   // one tick beat; called and returns at a falling edge
   task automatic send_tick(bit level, bit raise);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_addr_in_level = level;
      req_raise_irq     = raise;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      @(negedge clock);
   endtask

   // hold the sender off until every expected result has arrived
   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(dcpa_pkg::csr_idx_type idx,
                            bit [dcpa_pkg::CsrDatWidth-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      @(negedge clock);
   endtask

   // pulse trains with random content, line noise and one mid-phase drain
   task automatic run_phase(int budget, int tmo, int half);
      int  first;
      int  kind;
      int  n;
      int  gap;
      int  train;
      int  max_len;
      bit  drained;
      first   = ticks_sent;
      drained = 1'b0;
      while (ticks_sent - first < budget) begin
         if (!drained && ticks_sent - first >= budget / 2) begin
            drained = 1'b1;
            drain();
         end
         kind = $urandom_range(0, 9);
         // long burst so the edge count can pass 255 and wrap while the timeout never fires
         if (tmo == 65535 && ticks_sent == first)
            kind = 10;
         if (kind < 7 || kind == 10) begin
            if (kind == 10)
               n = $urandom_range(250, 260);
            else if ($urandom_range(0, 7) == 0)
               n = $urandom_range(1, 15);
            else
               n = 2 * $urandom_range(1, 8);
            max_len = (kind == 10) ? 1 : 2;
            send_tick(1'b1, rand_raise());
            repeat (n) begin
               repeat ($urandom_range(1, max_len)) send_tick(1'b0, rand_raise());
               repeat ($urandom_range(1, max_len)) send_tick(1'b1, rand_raise());
            end
            // quiet line until the timeout or the gap cap, then ride out the forwarded train up to its cap
            gap = ((tmo > 40) ? 40 : tmo) + $urandom_range(0, 2);
            repeat (gap) send_tick(1'b1, rand_raise());
            train = (n + 2) * 2 * half;
            if (train > 150)
               train = 150;
            repeat (train) send_tick($urandom_range(0, 3) != 0, rand_raise());
         end else begin
            repeat ($urandom_range(1, 20))
               send_tick($urandom_range(0, 1) != 0, rand_raise());
         end
      end
   endtask

   // stimulus
   initial begin
      // directed beats: bit 1 raise, bit 0 line level
      int dir_beats[] = '{1, 2, 1, 0, 1, 1, 1, 0, 1, 2, 1, 0, 1, 1, 1,
                          3, 0, 1, 1, 1, 1, 0, 1, 1, 1};
      int phase_tmo[]  = '{5, 1, 12, 65535, 2, 8, 20};
      int phase_rel[]  = '{3, 1, 255, 30, 4, 10, 2};
      int phase_half[] = '{2, 1, 3, 2, 65535, 1, 4};
      int idle_pct[]   = '{0, 62, 0, 26};
      int stall_pct[]  = '{0, 0, 62, 26};
      int w;

      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short timeout and fastest train for the directed part
      write_reg(dcpa_pkg::CSR_TIMEOUT_TICKS, 16'd3);
      write_reg(dcpa_pkg::CSR_TIMEOUTS_PER_RELEASE, 16'd2);
      write_reg(dcpa_pkg::CSR_PULSE_HALF_TICKS, 16'd1);
      foreach (dir_beats[i])
         send_tick(dir_beats[i][0], dir_beats[i][1]);

      foreach (phase_tmo[p]) begin
         drain();
         write_reg(dcpa_pkg::CSR_TIMEOUT_TICKS, 16'(phase_tmo[p]));
         write_reg(dcpa_pkg::CSR_TIMEOUTS_PER_RELEASE, 16'(phase_rel[p]));
         write_reg(dcpa_pkg::CSR_PULSE_HALF_TICKS, 16'(phase_half[p]));
         sender_idle_pct = idle_pct[p % 4];
         rsp_stall_pct   = stall_pct[p % 4];
         run_phase(150, phase_tmo[p], phase_half[p]);
      end

      // wait for the last results, with a timeout, before the final check
      req_valid = 1'b0;
      for (w = 0; w < 2000 && sb.pending() != 0; w++)
         @(negedge clock);
      repeat (5) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* daisy_chain_pulse_address.f */
sv/dcpa_pkg.sv
sv/daisy_chain_pulse_address.sv
test/daisy_chain_pulse_address_tb.sv
